// ===== rtl/bvm_pkg.sv =====
// Shared types, widths and constants of the battery low-voltage monitor.
package bvm_pkg;

	// Field and register widths
	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 15;
	localparam int CV_W       = 12;
	localparam int RUN_W      = 9;
	localparam int THR_W      = 11;
	localparam int LIMIT_W    = 8;
	localparam int SCALE_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int BYTE_W     = 8;
	localparam int WHOLE_W    = 6;
	localparam int FRAC_W     = 7;
	localparam int POS_W      = 4;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	// Division by five as a reciprocal multiply: exact for sums below 43690
	localparam int                 DIV5_PROD_W = 2 * SUM_W;
	localparam logic [SUM_W-1:0]   DIV5_MUL    = 15'd26215;
	localparam int                 DIV5_SHIFT  = 17;

	// Scaling to centivolts drops eleven fraction bits
	localparam int CV_PROD_W = SAMPLE_W + SCALE_W;
	localparam int CV_SHIFT  = 11;

	// Division by one hundred as a reciprocal multiply: exact for values below 4681
	localparam int                 DIV100_PROD_W = CV_W + 11;
	localparam logic [10:0]        DIV100_MUL    = 11'd1311;
	localparam int                 DIV100_SHIFT  = 17;
	localparam logic [CV_W-1:0]    CV_HUNDRED    = 12'd100;

	// Run counter saturation value
	localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

	// Operation codes on the input tuser
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// Result kinds on the output tuser
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FRAME  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 2'd2;

	// Configuration reset values
	localparam logic [THR_W-1:0]   THRESHOLD_RESET = 11'd960;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd100;
	localparam logic [SCALE_W-1:0] SCALE_RESET     = 11'd825;

	// Report frame byte positions
	localparam logic [POS_W-1:0] POS_HEAD  = 4'd0;
	localparam logic [POS_W-1:0] POS_TAG   = 4'd1;
	localparam logic [POS_W-1:0] POS_LEN   = 4'd2;
	localparam logic [POS_W-1:0] POS_WHOLE = 4'd3;
	localparam logic [POS_W-1:0] POS_FRAC  = 4'd4;
	localparam logic [POS_W-1:0] POS_SUM   = 4'd9;
	localparam logic [POS_W-1:0] POS_TAIL  = 4'd10;

	// Report frame constant bytes
	localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'h55;
	localparam logic [BYTE_W-1:0] FRAME_TAG  = 8'h06;
	localparam logic [BYTE_W-1:0] FRAME_LEN  = 8'h06;
	localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'hBB;

	// Default depth of the command queue
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	// Classified command passed from the front end to the back end
	typedef struct packed {
		logic               kind;
		logic               ok;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
	} cmd_t;

endpackage

// ===== rtl/battery_low_voltage_monitor_core.sv =====
// Top level of the battery low-voltage monitor: configuration registers, front end, queue, back end.
// An accepted item passes the front-end stages and the queue before its first result is presented.
// Throughput: a new item can be accepted every cycle unless the front end stalls on a full queue;
// the back end sends one result per cycle unless stalled: one for a check, eleven bytes for a report.
// Reset: arst_n clears the low-voltage state to normal, the run counter, the queue and the
// pipeline valid bits, and loads the configuration registers with their default values.
module battery_low_voltage_monitor_core import bvm_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample_a [11:0], sample_b [23:12], sample_c [35:24], sample_d [47:36], sample_e [59:48]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation [0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// battery_ok [0], frame_byte [8:1]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// result_kind [0]
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [THR_W-1:0]   low_threshold_q;
	logic [LIMIT_W-1:0] low_limit_q;
	logic [SCALE_W-1:0] scale_q;
	logic               push, pop, queue_full, head_valid;
	cmd_t               push_cmd, head_cmd;
	logic               out_ok;
	logic [BYTE_W-1:0]  out_byte;

	// Configuration registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q <= THRESHOLD_RESET;
			low_limit_q     <= LIMIT_RESET;
			scale_q         <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THRESHOLD: low_threshold_q <= cfg_wdata[THR_W-1:0];
				REG_LOW_LIMIT:     low_limit_q     <= cfg_wdata[LIMIT_W-1:0];
				REG_SCALE:         scale_q         <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end
	bvm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_op         (s_tuser),
		.in_a          (s_tdata[11:0]),
		.in_b          (s_tdata[23:12]),
		.in_c          (s_tdata[35:24]),
		.in_d          (s_tdata[47:36]),
		.in_e          (s_tdata[59:48]),
		.low_threshold (low_threshold_q),
		.low_limit     (low_limit_q),
		.scale         (scale_q),
		.queue_full    (queue_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// Command queue
	bvm_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Back end
	bvm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_ok     (out_ok),
		.out_byte   (out_byte),
		.out_last   (m_tlast)
	);

	// Output data packing with zero fill
	assign m_tdata = {(OUT_DATA_W - BYTE_W - 1)'(0), out_byte, out_ok};

endmodule

// ===== rtl/bvm_front.sv =====
// Front end: averaging and scaling pipeline, low-voltage state and command classification.
module bvm_front import bvm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [SAMPLE_W-1:0] in_a,
	input  logic [SAMPLE_W-1:0] in_b,
	input  logic [SAMPLE_W-1:0] in_c,
	input  logic [SAMPLE_W-1:0] in_d,
	input  logic [SAMPLE_W-1:0] in_e,
	input  logic [THR_W-1:0]    low_threshold,
	input  logic [LIMIT_W-1:0]  low_limit,
	input  logic [SCALE_W-1:0]  scale,
	input  logic                queue_full,
	output logic                push,
	output cmd_t                push_cmd
);

	logic                     en;
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic                     op_s1, op_s2, op_s3, op_s4;
	logic [SUM_W-1:0]         sum_s1;
	logic [SAMPLE_W-1:0]      avg_s2;
	logic [CV_W-1:0]          cv_s3, cv_s4;
	logic [WHOLE_W-1:0]       whole_s4;
	logic [DIV5_PROD_W-1:0]   avg_prod;
	logic [CV_PROD_W-1:0]     cv_prod;
	logic [DIV100_PROD_W-1:0] whole_prod;
	logic [CV_W-1:0]          frac_full;
	logic                     ok_q;
	logic [RUN_W-1:0]         run_q;
	logic [RUN_W-1:0]         run_inc;
	logic                     is_low;
	logic                     ok_next;
	logic [RUN_W-1:0]         run_next;

	// The whole pipeline advances unless the last stage cannot hand over its command
	assign en       = !(v_s4 && queue_full);
	assign in_ready = en;
	assign push     = v_s4 && !queue_full;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Reciprocal multiplies for the average, the scaling and the split into hundreds
	assign avg_prod   = DIV5_PROD_W'(sum_s1) * DIV5_PROD_W'(DIV5_MUL);
	assign cv_prod    = CV_PROD_W'(avg_s2) * CV_PROD_W'(scale);
	assign whole_prod = DIV100_PROD_W'(cv_s3) * DIV100_PROD_W'(DIV100_MUL);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1   <= SUM_W'(in_a) + SUM_W'(in_b) + SUM_W'(in_c) + SUM_W'(in_d)
			            + SUM_W'(in_e);
			op_s1    <= in_op;
			avg_s2   <= avg_prod[DIV5_SHIFT +: SAMPLE_W];
			op_s2    <= op_s1;
			cv_s3    <= cv_prod[CV_SHIFT +: CV_W];
			op_s3    <= op_s2;
			cv_s4    <= cv_s3;
			whole_s4 <= whole_prod[DIV100_SHIFT +: WHOLE_W];
			op_s4    <= op_s3;
		end
	end

	// Remainder of the division by one hundred
	assign frac_full = cv_s4 - CV_W'(whole_s4) * CV_HUNDRED;

	// Next low-voltage state for a check command
	assign is_low  = cv_s4 < CV_W'(low_threshold);
	assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + 9'd1;

	always_comb begin
		ok_next  = ok_q;
		run_next = run_q;
		if (op_s4 == OP_CHECK && ok_q) begin
			if (is_low) begin
				run_next = run_inc;
				if (run_inc > RUN_W'(low_limit)) begin
					ok_next = 1'b0;
				end
			end else begin
				run_next = '0;
			end
		end
	end

	// State changes only when the command leaves for the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b1;
			run_q <= '0;
		end else if (push) begin
			ok_q  <= ok_next;
			run_q <= run_next;
		end
	end

	// Command for the back end carries the state after this item
	always_comb begin
		push_cmd.kind  = (op_s4 == OP_REPORT) ? KIND_FRAME : KIND_STATUS;
		push_cmd.ok    = ok_next;
		push_cmd.whole = whole_s4;
		push_cmd.frac  = frac_full[FRAC_W-1:0];
	end

`ifndef NO_ASSERTIONS
	// A latched low state never returns to normal
	a_low_latched: assert property (@(posedge clk) disable iff (!arst_n)
		!ok_q |=> !ok_q)
		else $error("low-voltage state cleared without reset");

	// The run counter is not touched when the command is not handed over
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(run_q))
		else $error("run counter changed without a transfer to the queue");
`endif

endmodule

// ===== rtl/bvm_queue.sv =====
// Short command queue that decouples the front end from the frame sequencer.
module bvm_queue import bvm_pkg::*; #(
	parameter int Depth = DEFAULT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(Depth - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(Depth);

	cmd_t             mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_DEPTH;
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	// Neither overflow nor underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !head_valid))
		else $error("command queue overflow or underflow");
`endif

endmodule

// ===== rtl/bvm_back.sv =====
// Back end: turns queued commands into status results and serial report frames.
module bvm_back import bvm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic              out_ok,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	logic              load;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] frame_byte;
	logic [BYTE_W-1:0] check_byte;
	logic              is_frame;
	logic              at_tail;

	// The output register takes a new result once the previous transfer is done
	assign load     = !out_valid || out_ready;
	assign is_frame = head_cmd.kind == KIND_FRAME;
	assign at_tail  = pos_q == POS_TAIL;
	assign pop      = load && head_valid && (!is_frame || at_tail);

	// Byte sum of the two voltage bytes
	assign check_byte = BYTE_W'(head_cmd.whole) + BYTE_W'(head_cmd.frac);

	// Frame byte at the current position; padding positions read as zero
	always_comb begin
		case (pos_q)
			POS_HEAD:  frame_byte = FRAME_HEAD;
			POS_TAG:   frame_byte = FRAME_TAG;
			POS_LEN:   frame_byte = FRAME_LEN;
			POS_WHOLE: frame_byte = BYTE_W'(head_cmd.whole);
			POS_FRAC:  frame_byte = BYTE_W'(head_cmd.frac);
			POS_SUM:   frame_byte = check_byte;
			POS_TAIL:  frame_byte = FRAME_TAIL;
			default:   frame_byte = '0;
		endcase
	end

	// Position within the frame being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HEAD;
		end else if (load && head_valid && is_frame) begin
			pos_q <= at_tail ? POS_HEAD : pos_q + POS_W'(1);
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= head_valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_kind <= head_cmd.kind;
			out_ok   <= head_cmd.ok;
			out_byte <= is_frame ? frame_byte : '0;
			out_last <= !is_frame || at_tail;
		end
	end

`ifndef NO_ASSERTIONS
	// A status result is always the only and last result of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |-> out_last && out_byte == '0)
		else $error("status result without last marker or with data byte");

	// A frame in progress keeps its report command at the queue head
	a_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != POS_HEAD |-> head_valid && is_frame)
		else $error("frame position advanced without a report command");
`endif

endmodule
